// ===== src/cascaded_iir_filter_macros.svh =====
// assertion macros for the cascaded iir filter checker
// no dependencies
`ifndef CASCADED_IIR_FILTER_MACROS_SVH
`define CASCADED_IIR_FILTER_MACROS_SVH

// property checked while reset is low
`define CIIR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define CIIR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ciir_pkg.sv =====
// shared constants, types and address helper for the cascaded iir filter
// no dependencies
`default_nettype none
package ciir_pkg;
   localparam int MAX_ORDER  = 16;
   localparam int NUM_STAGES = 2;
   localparam int TAPS       = MAX_ORDER + 1;
   localparam int DEPTH      = NUM_STAGES * TAPS;
   localparam int RAM_DEPTH  = 2 * DEPTH;
   localparam int ADDR_W     = $clog2(RAM_DEPTH);
   localparam int TAP_W      = $clog2(TAPS);
   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 48;
   localparam int HALF_W     = COEF_W / 2;
   localparam int ACC_W      = 80;
   localparam int FRAC_SHIFT = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_EN1  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORD1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EN2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORD2 = 3'd3;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_COEF   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_XWR, ST_RUN, ST_DRAIN, ST_ROUND, ST_YWR, ST_EMIT
   } ciir_state_type;

   function automatic logic [ADDR_W-1:0] ciir_addr(input logic set, input logic stage,
                                                   input logic [TAP_W-1:0] off);
      logic [ADDR_W-1:0] a;
      a = (set ? ADDR_W'(DEPTH) : '0) + (stage ? ADDR_W'(TAPS) : '0) + ADDR_W'(off);
      return a;
   endfunction
endpackage
`default_nettype wire

// ===== src/ciir_if.sv =====
// valid/ready channel interfaces for samples, results and register writes
// depends on ciir_pkg
`default_nettype none
interface ciir_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  mode;
   logic signed [ciir_pkg::SAMPLE_W-1:0]  sample_in;
   logic                                  coef_stage;
   logic                                  coef_set;
   logic [4:0]                            coef_index;
   logic signed [ciir_pkg::COEF_W-1:0]    coef_value;
   modport source (output valid, mode, sample_in, coef_stage, coef_set, coef_index,
                   coef_value, input ready);
   modport sink (input valid, mode, sample_in, coef_stage, coef_set, coef_index,
                 coef_value, output ready);
endinterface

interface ciir_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ciir_pkg::SAMPLE_W-1:0]  sample_out;
   modport source (output valid, sample_out, input ready);
   modport sink (input valid, sample_out, output ready);
endinterface

interface ciir_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [ciir_pkg::CSR_IDX_W-1:0]        index;
   logic [ciir_pkg::CSR_DATA_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/ciir_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none
module ciir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// ===== src/cascaded_iir_filter.sv =====
// cascaded direct-form-I iir filter top level
// depends on ciir_pkg, ciir_if and ciir_ram
//
// req_chan carries one transaction per item: mode 1 loads one coefficient word
// (feedforward or feedback, stage, tap) and gives no result; mode 0 filters a
// sample through each enabled stage and gives one result on rsp_chan.
// csr_chan writes the enable and order registers, always ready; write only
// while the block is idle.
// Coefficients and both history lines live in two rams (coefficients, history)
// read one term per cycle; one shared 48x24 multiply-accumulate does all work.
// Per enabled stage a sample passes ST_XWR, ST_RUN (the term loop of the shared
// multiplier), ST_DRAIN, ST_ROUND and ST_YWR; ST_EMIT then gives the result.
// A coefficient load is written from ST_IDLE. A new item is accepted once the
// previous one has finished, while its result may still wait in the output
// register; a stalled receiver holds rsp_chan valid and stops the block only
// when a further result is ready.
// Reset (synchronous) clears the registers to their defaults, the histories
// to zero and the output register; coefficients must be loaded before use.
`default_nettype none
module cascaded_iir_filter (
   input wire logic clock,
   input wire logic reset,
   ciir_req_if.sink   req_chan,
   ciir_rsp_if.source rsp_chan,
   ciir_csr_if.sink   csr_chan
);
   import ciir_pkg::*;

   ciir_state_type state_ff, state_in;
   logic en1_ff, en1_in, en2_ff, en2_in;
   logic [CSR_DATA_W-1:0] ord1_ff, ord1_in, ord2_ff, ord2_in;
   logic stage_ff, stage_in, set_ff, set_in, drain_ff, drain_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic [TAP_W-1:0] ptr_ff [NUM_STAGES];
   logic [TAP_W-1:0] ptr_in [NUM_STAGES];
   logic [RAM_DEPTH-1:0] hv_ff, hv_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in, y_ff, y_in, out_data_ff, out_data_in;
   logic out_valid_ff, out_valid_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic v1_ff, v2_ff, usex1_ff, hv1_ff, issue;
   logic signed [2*HALF_W:0] plo_ff;
   logic signed [2*HALF_W-1:0] phi_ff;

   logic c_we, h_we;
   logic [ADDR_W-1:0] c_waddr, h_waddr, c_raddr, h_raddr;
   logic [COEF_W-1:0] c_wdata, c_rdata;
   logic [SAMPLE_W-1:0] h_wdata, h_rdata;

   logic [CSR_DATA_W-1:0] ord_raw;
   logic [TAP_W-1:0] ord_sat, ptr_cur, hoff;
   logic [TAP_W:0] hsum;
   logic signed [SAMPLE_W-1:0] msamp, y_sat;
   logic signed [ACC_W-1:0] rnd, q;
   logic out_free, req_acc;

   ciir_ram #(.WIDTH(COEF_W), .DEPTH(RAM_DEPTH)) u_coef_ram (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata));

   ciir_ram #(.WIDTH(SAMPLE_W), .DEPTH(RAM_DEPTH)) u_hist_ram (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.sample_out = out_data_ff;
   assign req_acc = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   assign ord_raw = stage_ff ? ord2_ff : ord1_ff;
   assign ord_sat = (int'(ord_raw) > MAX_ORDER) ? TAP_W'(MAX_ORDER) : ord_raw[TAP_W-1:0];
   assign ptr_cur = ptr_ff[stage_ff];
   assign hsum = {1'b0, ptr_cur} + (TAP_W+1)'(TAPS) - {1'b0, tap_ff};
   assign hoff = (int'(hsum) >= TAPS) ? TAP_W'(hsum - (TAP_W+1)'(TAPS)) : hsum[TAP_W-1:0];
   assign c_raddr = ciir_addr(set_ff, stage_ff, tap_ff);
   assign h_raddr = ciir_addr(set_ff, stage_ff, hoff);

   // multiply stage and accumulate stage
   assign msamp = usex1_ff ? x_ff : (hv1_ff ? $signed(h_rdata) : '0);
   assign rnd = acc_ff + ACC_W'(64'sd1 <<< (FRAC_SHIFT - 1));
   assign q = rnd >>> FRAC_SHIFT;
   assign y_sat = (q > ACC_W'(64'sd8388607)) ? 24'sh7fffff :
                  (q < -ACC_W'(64'sd8388608)) ? 24'sh800000 : q[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      plo_ff <= $signed({1'b0, c_rdata[HALF_W-1:0]}) * msamp;
      phi_ff <= $signed(c_rdata[COEF_W-1:HALF_W]) * msamp;
      usex1_ff <= (set_ff == 1'b0) && (tap_ff == '0);
      hv1_ff <= hv_ff[h_raddr];
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      out_data_ff <= out_data_in;
      tap_ff <= tap_in;
      set_ff <= set_in;
      drain_ff <= drain_in;
      stage_ff <= stage_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         en1_ff <= 1'b1;
         ord1_ff <= CSR_DATA_W'(2);
         en2_ff <= 1'b0;
         ord2_ff <= CSR_DATA_W'(2);
         hv_ff <= '0;
         out_valid_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int s = 0; s < NUM_STAGES; s++) begin
            ptr_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         en1_ff <= en1_in;
         ord1_ff <= ord1_in;
         en2_ff <= en2_in;
         ord2_ff <= ord2_in;
         hv_ff <= hv_in;
         out_valid_ff <= out_valid_in;
         v1_ff <= issue;
         v2_ff <= v1_ff;
         for (int s = 0; s < NUM_STAGES; s++) begin
            ptr_ff[s] <= ptr_in[s];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      en1_in = en1_ff;
      ord1_in = ord1_ff;
      en2_in = en2_ff;
      ord2_in = ord2_ff;
      stage_in = stage_ff;
      set_in = set_ff;
      tap_in = tap_ff;
      drain_in = drain_ff;
      ptr_in = ptr_ff;
      hv_in = hv_ff;
      x_in = x_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      out_data_in = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      issue = 1'b0;
      c_we = 1'b0;
      c_waddr = ciir_addr(req_chan.coef_set, req_chan.coef_stage,
                          req_chan.coef_index[TAP_W-1:0]);
      c_wdata = req_chan.coef_value;
      h_we = 1'b0;
      h_waddr = ciir_addr(1'b0, stage_ff, ptr_cur);
      h_wdata = x_ff;

      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_EN1:  en1_in = csr_chan.data[0];
            CSR_ORD1: ord1_in = csr_chan.data;
            CSR_EN2:  en2_in = csr_chan.data[0];
            CSR_ORD2: ord2_in = csr_chan.data;
            default: ;
         endcase
      end

      if (v2_ff) begin
         acc_in = acc_ff + (ACC_W'(phi_ff) <<< HALF_W) + ACC_W'(plo_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.mode == MODE_COEF) begin
                  c_we = (int'(req_chan.coef_stage) < NUM_STAGES) &&
                         (int'(req_chan.coef_index) <= MAX_ORDER);
               end else begin
                  x_in = req_chan.sample_in;
                  if (en1_ff) begin
                     stage_in = 1'b0;
                     state_in = ST_XWR;
                  end else if (NUM_STAGES > 1 && en2_ff) begin
                     stage_in = 1'b1;
                     state_in = ST_XWR;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_XWR: begin
            h_we = 1'b1;
            hv_in[h_waddr] = 1'b1;
            tap_in = '0;
            set_in = 1'b0;
            acc_in = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            issue = 1'b1;
            if (tap_ff == ord_sat && (set_ff || ord_sat == '0)) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else if (!set_ff && tap_ff == ord_sat) begin
               set_in = 1'b1;
               tap_in = TAP_W'(1);
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            y_in = y_sat;
            state_in = ST_YWR;
         end
         ST_YWR: begin
            h_we = 1'b1;
            h_waddr = ciir_addr(1'b1, stage_ff, ptr_cur);
            h_wdata = y_ff;
            hv_in[h_waddr] = 1'b1;
            ptr_in[stage_ff] = (int'(ptr_cur) == MAX_ORDER) ? '0 : ptr_cur + TAP_W'(1);
            x_in = y_ff;
            if (!stage_ff && NUM_STAGES > 1 && en2_ff) begin
               stage_in = 1'b1;
               state_in = ST_XWR;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in = x_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== src/ciir_checker.sv =====
// port-level checks of the cascaded iir filter, bound to the top level
// depends on cascaded_iir_filter_macros.svh
`default_nettype none
`include "cascaded_iir_filter_macros.svh"
module ciir_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_mode,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);
   // result holds until taken
   `CIIR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   // a sample transaction keeps the input closed next cycle
   `CIIR_ASSERT(a_busy, clock, reset, req_valid && req_ready && !req_mode |=> !req_ready, "busy")
   // a coefficient load never creates a result
   `CIIR_ASSERT(a_coef_quiet, clock, reset, req_valid && req_ready && req_mode && !rsp_valid |=> !rsp_valid, "coef rsp")
   // reset empties the output
   `CIIR_ASSERT_ALWAYS(a_reset_out, clock, reset |=> !rsp_valid, "rsp after reset")
endmodule

bind cascaded_iir_filter ciir_checker u_ciir_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready), .req_mode(req_chan.mode),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready)
);
`default_nettype wire

// ===== dv/cascaded_iir_filter_test.sv =====
// self-checking testbench for the cascaded direct-form-I iir filter
// depends on ciir_pkg, ciir_if and the cascaded_iir_filter rtl
// a local q1.23/q20.28 filter predictor checks every result under random idling
`default_nettype none
module cascaded_iir_filter_test;
   import ciir_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 60;

   typedef struct {
      logic                       mode;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       stage;
      logic                       set;
      logic [4:0]                 index;
      logic signed [COEF_W-1:0]   value;
   } filter_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ciir_req_if req_chan ();
   ciir_rsp_if rsp_chan ();
   ciir_csr_if csr_chan ();

   cascaded_iir_filter uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   always #5 clock = ~clock;

   filter_item_type             pending_items[$];
   logic signed [SAMPLE_W-1:0]  expected_samples[$];
   filter_item_type             driven_item;
   int                          send_gap;
   int                          recv_stall;
   bit                          no_idle;
   int                          error_count;
   int                          cycle_count;

   logic                        stage_enable[2];
   logic [4:0]                  stage_order[2];
   logic signed [COEF_W-1:0]    ff_coef[2][TAPS];
   logic signed [COEF_W-1:0]    fb_coef[2][TAPS];
   logic signed [SAMPLE_W-1:0]  x_hist[2][TAPS];
   logic signed [SAMPLE_W-1:0]  y_hist[2][TAPS];

   function automatic logic signed [SAMPLE_W-1:0] filter_stage(int st,
                                                               logic signed [SAMPLE_W-1:0] x);
      int ord;
      logic signed [95:0] acc;
      logic signed [95:0] a;
      logic signed [95:0] b;
      logic signed [95:0] q;
      logic signed [SAMPLE_W-1:0] y;
      ord = (stage_order[st] > MAX_ORDER) ? MAX_ORDER : int'(stage_order[st]);
      x_hist[st][0] = x;
      acc = '0;
      for (int i = 0; i <= ord; i++) begin
         a = ff_coef[st][i];
         b = x_hist[st][i];
         acc = acc + a * b;
         if (i > 0) begin
            a = fb_coef[st][i];
            b = y_hist[st][i];
            acc = acc + a * b;
         end
      end
      q = (acc + 96'sd134217728) >>> FRAC_SHIFT;
      if (q > 96'sd8388607) y = 24'sd8388607;
      else if (q < -96'sd8388608) y = -24'sd8388608;
      else y = q[SAMPLE_W-1:0];
      y_hist[st][0] = y;
      for (int i = MAX_ORDER; i > 0; i--) begin
         x_hist[st][i] = x_hist[st][i-1];
         y_hist[st][i] = y_hist[st][i-1];
      end
      return y;
   endfunction

   function automatic void predict_item(filter_item_type it);
      logic signed [SAMPLE_W-1:0] s;
      if (it.mode == MODE_COEF) begin
         if (it.index <= MAX_ORDER) begin
            if (it.set) fb_coef[it.stage][it.index] = it.value;
            else ff_coef[it.stage][it.index] = it.value;
         end
      end else begin
         s = it.sample;
         if (stage_enable[0]) s = filter_stage(0, s);
         if (stage_enable[1]) s = filter_stage(1, s);
         expected_samples.push_back(s);
      end
   endfunction

   function automatic filter_item_type sample_item(logic signed [SAMPLE_W-1:0] s);
      filter_item_type it;
      it.mode = MODE_SAMPLE;
      it.sample = s;
      it.stage = 1'($urandom_range(0, 1));
      it.set = 1'($urandom_range(0, 1));
      it.index = 5'($urandom_range(0, 31));
      it.value = COEF_W'({$urandom, $urandom});
      return it;
   endfunction

   function automatic filter_item_type coef_item(logic st, logic set, logic [4:0] idx,
                                                 logic signed [COEF_W-1:0] v);
      filter_item_type it;
      it.mode = MODE_COEF;
      it.sample = SAMPLE_W'($urandom);
      it.stage = st;
      it.set = set;
      it.index = idx;
      it.value = v;
      return it;
   endfunction

   function automatic logic signed [COEF_W-1:0] random_coef(logic set);
      int pick;
      logic signed [COEF_W-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 75) v = $signed(COEF_W'($urandom_range(0, 1 << 25))) - (set ? 48'sd8388608
                                                                             : 48'sd16777216);
      else if (pick < 88) v = $signed(COEF_W'($urandom_range(0, 1 << 30))) - 48'sd536870912;
      else v = COEF_W'({$urandom, $urandom});
      return v;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) return 24'sd8388607;
      if (pick < 6) return -24'sd8388608;
      if (pick < 8) return '0;
      return SAMPLE_W'($urandom);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) predict_item(driven_item);
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               driven_item = pending_items.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.mode <= driven_item.mode;
               req_chan.sample_in <= driven_item.sample;
               req_chan.coef_stage <= driven_item.stage;
               req_chan.coef_set <= driven_item.set;
               req_chan.coef_index <= driven_item.index;
               req_chan.coef_value <= driven_item.value;
               send_gap <= no_idle ? 0 : $urandom_range(0, 10);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected result transaction, expected none actual %0d",
                        $time, rsp_chan.sample_out);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_chan.sample_out !== want) begin
                  $display("%0t: sample_out mismatch, expected %0d actual %0d",
                           $time, want, rsp_chan.sample_out);
                  error_count++;
               end
            end
            recv_stall <= no_idle ? 0 : $urandom_range(0, 10);
            rsp_chan.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_chan.valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= d;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_EN1: stage_enable[0] = d[0];
         CSR_ORD1: stage_order[0] = d;
         CSR_EN2: stage_enable[1] = d[0];
         CSR_ORD2: stage_order[1] = d;
         default: ;
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_stages(logic e1, logic [4:0] o1, logic e2, logic [4:0] o2);
      write_reg(CSR_EN1, {4'b0, e1});
      write_reg(CSR_ORD1, o1);
      write_reg(CSR_EN2, {4'b0, e2});
      write_reg(CSR_ORD2, o2);
   endtask

   task automatic queue_random(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 15)
            pending_items.push_back(coef_item(1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)),
               ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16)),
               random_coef(1'b0)));
         else
            pending_items.push_back(sample_item(random_sample()));
      end
   endtask

   initial begin
      logic e1, e2;
      logic [4:0] o1, o2;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_SAMPLE;
      req_chan.sample_in = '0;
      req_chan.coef_stage = 1'b0;
      req_chan.coef_set = 1'b0;
      req_chan.coef_index = '0;
      req_chan.coef_value = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      error_count = 0;
      cycle_count = 0;
      no_idle = 1'b0;
      stage_enable[0] = 1'b1;
      stage_enable[1] = 1'b0;
      stage_order[0] = 5'd2;
      stage_order[1] = 5'd2;
      for (int s = 0; s < 2; s++)
         for (int i = 0; i < TAPS; i++) begin
            ff_coef[s][i] = '0;
            fb_coef[s][i] = '0;
            x_hist[s][i] = '0;
            y_hist[s][i] = '0;
         end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every coefficient is loaded before any sample is filtered
      for (int s = 0; s < 2; s++)
         for (int i = 0; i < TAPS; i++) begin
            pending_items.push_back(coef_item(1'(s), 1'b0, 5'(i), random_coef(1'b0)));
            pending_items.push_back(coef_item(1'(s), 1'b1, 5'(i), random_coef(1'b1)));
         end

      // directed
      pending_items.push_back(sample_item(24'sd8388607));
      pending_items.push_back(sample_item(-24'sd8388608));
      pending_items.push_back(sample_item('0));
      pending_items.push_back(sample_item(-24'sd1));
      pending_items.push_back(sample_item(24'sd1));
      pending_items.push_back(coef_item(1'b0, 1'b0, 5'd0, 48'sh7FFF_FFFF_FFFF));
      pending_items.push_back(sample_item(24'sd8388607));
      pending_items.push_back(sample_item(-24'sd8388608));
      pending_items.push_back(coef_item(1'b0, 1'b0, 5'd0, 48'sh8000_0000_0000));
      pending_items.push_back(sample_item(24'sd8388607));
      pending_items.push_back(sample_item(-24'sd8388608));
      pending_items.push_back(coef_item(1'b0, 1'b0, 5'd0, 48'sd268435456));
      pending_items.push_back(coef_item(1'b0, 1'b0, 5'd17, 48'sh7FFF_FFFF_FFFF));
      pending_items.push_back(coef_item(1'b1, 1'b1, 5'd31, 48'sh8000_0000_0000));
      pending_items.push_back(coef_item(1'b0, 1'b1, 5'd0, 48'sh7FFF_FFFF_FFFF));
      pending_items.push_back(sample_item(24'sd4194304));
      pending_items.push_back(sample_item(-24'sd4194304));
      wait_drained();

      for (int phase = 0; phase < 13; phase++) begin
         case (phase)
            0: set_stages(1'b0, 5'd2, 1'b0, 5'd2);
            1: set_stages(1'b1, 5'd16, 1'b1, 5'd16);
            2: set_stages(1'b1, 5'd0, 1'b1, 5'd0);
            3: set_stages(1'b1, 5'd31, 1'b1, 5'd17);
            4: set_stages(1'b0, 5'd5, 1'b1, 5'd1);
            default: begin
               e1 = 1'($urandom_range(0, 1));
               e2 = 1'($urandom_range(0, 1));
               o1 = 5'($urandom_range(0, 31));
               o2 = 5'($urandom_range(0, 31));
               set_stages(e1, o1, e2, o2);
            end
         endcase
         no_idle = (phase % 4 == 2);
         queue_random(120);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
